// ===== sv/rsb_pkg.sv =====
// Shared constants and types for the rewinding sample buffer.
package rsb_pkg;

    localparam int DEPTH      = 4096;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int POS_W      = $clog2(DEPTH + 1);
    localparam int SIZE_W     = 13;
    localparam int CMP_W      = (POS_W > SIZE_W) ? POS_W : SIZE_W;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_SLOT_LIMIT = 1'b0;

    typedef struct packed {
        logic                accepted;
        logic                read_valid;
        logic [CNT_W-1:0]    skipped_total;
        logic                is_empty;
        logic                is_full;
        logic                is_blocked;
        logic                at_wrap;
    } res_t;

endpackage

// ===== sv/rsb_ram.sv =====
// Generic single-port RAM with registered read data.
module rsb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rsb_apb.sv =====
// APB configuration register block holding the slot limit.
module rsb_apb (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rsb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rsb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [rsb_pkg::SIZE_W-1:0]       slot_limit
);

    logic [rsb_pkg::SIZE_W-1:0] size_reg;
    logic                       size_sel;
    logic                       wr_en;

    assign size_sel = (paddr[2] == rsb_pkg::REG_SLOT_LIMIT);
    assign wr_en    = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= rsb_pkg::SIZE_RESET;
        end
        else if (wr_en && size_sel)
        begin
            size_reg <= pwdata[rsb_pkg::SIZE_W-1:0];
        end
    end

    assign prdata     = size_sel ? rsb_pkg::APB_DATA_W'(size_reg) : '0;
    assign pready     = 1'b1;
    assign slot_limit = size_reg;

endmodule

// ===== sv/rsb_ctrl.sv =====
// Position tracking, drop and rewind decisions, and the result register.
module rsb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          mode,
    input  logic [rsb_pkg::SIZE_W-1:0]    slot_limit,
    output logic                          ram_we,
    output logic                          ram_re,
    output logic [rsb_pkg::ADDR_W-1:0]    ram_addr,
    output logic                          done,
    output rsb_pkg::res_t                 res
);

    localparam int CW = rsb_pkg::CMP_W;
    localparam int PW = rsb_pkg::POS_W;

    logic [PW-1:0]             wp_reg, wp_next;
    logic [PW-1:0]             rp_reg, rp_next;
    logic [rsb_pkg::CNT_W-1:0] skip_reg, skip_next;
    logic                      ew_reg, ew_next;
    logic                      done_reg;
    rsb_pkg::res_t             res_reg, res_next;

    logic [PW-1:0] eff_size;
    logic [PW-1:0] base;
    logic          full, blocked, caught_up;
    logic          full_n;

    // clamp the size to 1..DEPTH
    always_comb
    begin
        if (slot_limit == '0)
        begin
            eff_size = PW'(1);
        end
        else if (CW'(slot_limit) > CW'(rsb_pkg::DEPTH))
        begin
            eff_size = PW'(rsb_pkg::DEPTH);
        end
        else
        begin
            eff_size = PW'(CW'(slot_limit));
        end
    end

    assign full      = (wp_reg >= eff_size);
    assign caught_up = (rp_reg == wp_reg);
    assign blocked   = full && !caught_up;
    assign base      = full ? '0 : wp_reg;

    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        skip_next = skip_reg;
        ew_next   = ew_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = rp_reg[rsb_pkg::ADDR_W-1:0];
        res_next  = '0;
        if (accept)
        begin
            case (mode)
                rsb_pkg::MODE_WRITE:
                begin
                    if (blocked)
                    begin
                        skip_next = skip_reg + 1'b1;
                    end
                    else
                    begin
                        // rewind both positions when full and caught up
                        ram_we   = 1'b1;
                        ram_addr = base[rsb_pkg::ADDR_W-1:0];
                        wp_next  = base + 1'b1;
                        rp_next  = full ? '0 : rp_reg;
                        ew_next  = 1'b1;
                        res_next.accepted = 1'b1;
                    end
                end
                rsb_pkg::MODE_READ:
                begin
                    if (!caught_up)
                    begin
                        ram_re  = 1'b1;
                        rp_next = rp_reg + 1'b1;
                        res_next.read_valid = 1'b1;
                    end
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
        full_n                 = (wp_next >= eff_size);
        res_next.skipped_total = skip_next;
        res_next.is_empty      = !ew_next;
        res_next.is_full       = full_n;
        res_next.is_blocked    = full_n && (rp_next != wp_next);
        res_next.at_wrap       = full_n && ew_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            skip_reg <= '0;
            ew_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            skip_reg <= skip_next;
            ew_reg   <= ew_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    // reader never runs past the writer
    a_rp_le_wp: assert property (@(posedge clk) disable iff (!rst_n)
        rp_reg <= wp_reg)
        else $error("read position beyond write position");

    a_wp_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wp_reg != '0) |-> ew_reg)
        else $error("write position moved without a write");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("no result after an accepted transaction");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(res_reg.accepted && res_reg.read_valid))
        else $error("result marks both a write and a read");

    a_skip_only_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (skip_reg != $past(skip_reg)) |-> (done_reg && !res_reg.accepted
            && !res_reg.read_valid))
        else $error("skip count moved without a dropped write");

endmodule

// ===== sv/rewinding_sample_buffer.sv =====
// Top level of the rewinding sample buffer: APB registers, control and sample RAM.
//
// One transaction (a write or a read of one sample) is taken on every clock
// cycle; busy is never raised. Its result appears on the result ports, marked
// by done, exactly one cycle after start was sampled, and stays for that one
// cycle only: the receiver cannot hold it off and must take it then. The figure
// is set by the single-port sample RAM, which takes one access per cycle with
// registered read data. No clearing pass runs after reset: entries are only
// read after they have been written.
module rewinding_sample_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic signed [rsb_pkg::SAMPLE_W-1:0] sample,
    output logic                                done,
    output logic                                accepted,
    output logic signed [rsb_pkg::SAMPLE_W-1:0] read_sample,
    output logic                                read_valid,
    output logic [rsb_pkg::CNT_W-1:0]           skipped_total,
    output logic                                is_empty,
    output logic                                is_full,
    output logic                                is_blocked,
    output logic                                at_wrap,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsb_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rsb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rsb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    logic [rsb_pkg::SIZE_W-1:0]   slot_limit;
    logic                         ram_we;
    logic                         ram_re;
    logic [rsb_pkg::ADDR_W-1:0]   ram_addr;
    logic [rsb_pkg::SAMPLE_W-1:0] ram_rdata;
    logic                         accept;
    rsb_pkg::res_t                res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    rsb_apb u_apb (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .slot_limit (slot_limit)
    );

    rsb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .slot_limit (slot_limit),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .done       (done),
        .res        (res)
    );

    rsb_ram #(
        .WIDTH (rsb_pkg::SAMPLE_W),
        .DEPTH (rsb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    // zero the sample unless the read returned stored data
    assign read_sample   = res.read_valid ? ram_rdata : '0;
    assign accepted      = res.accepted;
    assign read_valid    = res.read_valid;
    assign skipped_total = res.skipped_total;
    assign is_empty      = res.is_empty;
    assign is_full       = res.is_full;
    assign is_blocked    = res.is_blocked;
    assign at_wrap       = res.at_wrap;

endmodule

// ===== test/rewinding_sample_buffer_tb.sv =====
// Self-checking bench for the rewinding sample buffer: command driver, result monitor, predictor.
module rewinding_sample_buffer_tb;
    import rsb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [APB_ADDR_W-1:0] SIZE_ADDR = {REG_SLOT_LIMIT, 2'b00};

    typedef struct {
        logic                       mode;
        logic signed [SAMPLE_W-1:0] sample;
    } sample_op_t;

    typedef struct {
        logic                       accepted;
        logic signed [SAMPLE_W-1:0] read_sample;
        logic                       read_valid;
        logic [CNT_W-1:0]           skipped_total;
        logic                       is_empty;
        logic                       is_full;
        logic                       is_blocked;
        logic                       at_wrap;
    } buffer_reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       start = 1'b0;
    logic                       mode = MODE_WRITE;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;

    logic                       busy;
    logic                       done;
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] read_sample;
    logic                       read_valid;
    logic [CNT_W-1:0]           skipped_total;
    logic                       is_empty;
    logic                       is_full;
    logic                       is_blocked;
    logic                       at_wrap;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    // predictor state, mirrored from the block
    logic signed [SAMPLE_W-1:0] stored [DEPTH];
    int unsigned                wr_at = 0;
    int unsigned                rd_at = 0;
    logic [CNT_W-1:0]           drops = '0;
    logic                       has_written = 1'b0;
    logic [SIZE_W-1:0]          size_setting = SIZE_RESET;

    sample_op_t    sample_ops [$];
    buffer_reply_t replies_due [$];
    sample_op_t    next_op;
    buffer_reply_t due;
    int unsigned   gap_left = 0;
    bit            gaps_on = 1'b1;
    int unsigned   mismatches = 0;
    int unsigned   cycle_count = 0;

    rewinding_sample_buffer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .sample        (sample),
        .done          (done),
        .accepted      (accepted),
        .read_sample   (read_sample),
        .read_valid    (read_valid),
        .skipped_total (skipped_total),
        .is_empty      (is_empty),
        .is_full       (is_full),
        .is_blocked    (is_blocked),
        .at_wrap       (at_wrap),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, want %0h", what, got, want));
    endtask

    // clamp the register to the slots actually usable
    function automatic int unsigned slots_in_use(input logic [SIZE_W-1:0] setting);
        if (setting == '0)
            return 1;
        if (setting > DEPTH)
            return DEPTH;
        return 32'(setting);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] any_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // apply one transaction to the mirrored buffer and queue the reply it gives
    function automatic void advance_buffer(input logic op_mode,
                                           input logic signed [SAMPLE_W-1:0] op_sample);
        buffer_reply_t reply;
        int unsigned   slots;
        slots = slots_in_use(size_setting);
        reply = '{default: '0};
        if (op_mode == MODE_WRITE)
        begin
            if (wr_at >= slots && rd_at != wr_at)
            begin
                drops = drops + 1'b1;
            end
            else
            begin
                if (wr_at >= slots)
                begin
                    wr_at = 0;
                    rd_at = 0;
                end
                stored[wr_at] = op_sample;
                wr_at++;
                has_written = 1'b1;
                reply.accepted = 1'b1;
            end
        end
        else if (rd_at != wr_at)
        begin
            reply.read_sample = stored[rd_at];
            reply.read_valid = 1'b1;
            rd_at++;
        end
        reply.skipped_total = drops;
        reply.is_empty = !has_written;
        reply.is_full = (wr_at >= slots);
        reply.is_blocked = reply.is_full && (rd_at != wr_at);
        reply.at_wrap = reply.is_full && has_written;
        replies_due.push_back(reply);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // driver: present one transaction at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
                advance_buffer(mode, sample);
            // hold a transaction the block has not taken yet
            if (!(start && busy))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (sample_ops.size() != 0)
                begin
                    next_op = sample_ops.pop_front();
                    start <= 1'b1;
                    mode <= next_op.mode;
                    sample <= next_op.sample;
                    gap_left = gaps_on ? pick_gap() : 0;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobed result must match the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                report_mismatch("result with nothing expected");
            end
            else
            begin
                due = replies_due.pop_front();
                check_field("accepted", 32'(accepted), 32'(due.accepted));
                check_field("read_sample", 32'(read_sample), 32'(due.read_sample));
                check_field("read_valid", 32'(read_valid), 32'(due.read_valid));
                check_field("skipped_total", skipped_total, due.skipped_total);
                check_field("is_empty", 32'(is_empty), 32'(due.is_empty));
                check_field("is_full", 32'(is_full), 32'(due.is_full));
                check_field("is_blocked", 32'(is_blocked), 32'(due.is_blocked));
                check_field("at_wrap", 32'(at_wrap), 32'(due.at_wrap));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_op(input logic op_mode, input logic signed [SAMPLE_W-1:0] op_sample);
        sample_op_t op;
        op.mode = op_mode;
        op.sample = op_sample;
        sample_ops.push_back(op);
    endtask

    // wait until every queued transaction has been sent and answered
    task automatic settle();
        do
            @(negedge clk);
        while (sample_ops.size() != 0 || start || replies_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic read_size(input logic [31:0] want);
        logic [APB_DATA_W-1:0] value;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= SIZE_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        // sample mid-cycle, clear of the edge
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        value = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        check_field("slot limit readback", value, want);
    endtask

    task automatic write_size(input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SIZE_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        size_setting = value[SIZE_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        read_size(32'(value[SIZE_W-1:0]));
    endtask

    initial
    begin
        int unsigned n;
        int unsigned burst;
        int unsigned slots;
        logic [31:0] size_word;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        read_size(32'(SIZE_RESET));

        // reader caught up on an empty buffer, then sample extremes
        queue_op(MODE_READ, any_sample());
        queue_op(MODE_WRITE, 16'sh7fff);
        queue_op(MODE_WRITE, 16'sh8000);
        queue_op(MODE_WRITE, 16'sh0000);
        queue_op(MODE_WRITE, 16'shffff);
        repeat (5) queue_op(MODE_READ, any_sample());
        settle();

        // single slot: rewind when caught up, drop while the reader lags
        write_size(32'd1);
        queue_op(MODE_WRITE, 16'sh1234);
        queue_op(MODE_WRITE, 16'sh4321);
        queue_op(MODE_READ, any_sample());
        queue_op(MODE_WRITE, 16'sh5555);
        settle();

        // zero behaves as one slot
        write_size(32'd0);
        queue_op(MODE_READ, any_sample());
        queue_op(MODE_WRITE, 16'shaaaa);
        queue_op(MODE_WRITE, 16'sh0f0f);
        settle();

        // lower the size below the write position
        write_size(32'd8);
        repeat (4) queue_op(MODE_WRITE, any_sample());
        queue_op(MODE_READ, any_sample());
        settle();
        write_size(32'd2);
        queue_op(MODE_WRITE, any_sample());
        repeat (4) queue_op(MODE_READ, any_sample());
        queue_op(MODE_WRITE, any_sample());
        settle();

        // size above the depth, back to back
        write_size(32'h0000_1fff);
        gaps_on = 1'b0;
        repeat (wr_at - rd_at) queue_op(MODE_READ, any_sample());
        repeat (8)
        begin
            queue_op(MODE_WRITE, any_sample());
            queue_op(MODE_READ, any_sample());
        end
        settle();

        for (int p = 0; p < 16; p++)
        begin
            if (p == 0)
                size_word = 32'd4096;
            else if (p == 1)
                size_word = 32'hffff_e003;
            else
            begin
                case ($urandom_range(0, 19))
                    0: size_word = 32'd0;
                    1: size_word = 32'($urandom_range(4097, 8191));
                    2, 3, 4: size_word = 32'($urandom_range(17, 300));
                    default: size_word = 32'($urandom_range(1, 16));
                endcase
                if ($urandom_range(0, 3) == 0)
                    size_word[31:SIZE_W] = (32 - SIZE_W)'($urandom);
            end
            write_size(size_word);
            slots = slots_in_use(size_word[SIZE_W-1:0]);
            gaps_on = ($urandom_range(0, 3) != 0);
            n = 0;
            while (n < 100)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // noise: any mix of reads and writes
                    burst = $urandom_range(1, 6);
                    repeat (burst) queue_op(1'($urandom), any_sample());
                    n += burst;
                end
                else
                begin
                    burst = $urandom_range(0, (slots < 40) ? slots + 3 : 40);
                    repeat (burst) queue_op(MODE_WRITE, any_sample());
                    n += burst;
                    burst = $urandom_range(0, burst + 2);
                    repeat (burst) queue_op(MODE_READ, any_sample());
                    n += burst;
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
